// ===== rtl/msrs_pkg.sv =====
// Package for the minimal standard random source: codes, command and status types, table ROM.
`timescale 1ns / 1ps
package msrs_pkg;

  // Generator constants
  localparam logic [30:0] MODM        = 31'h7FFF_FFFF;
  localparam logic [14:0] MULT        = 15'd16807;
  localparam logic [30:0] RESET_STATE = 31'd198195254;
  localparam logic [3:0]  GAUSS_LAST  = 4'd11;
  localparam logic [8:0]  TAB_STEPS   = 9'd200;

  // Command codes
  localparam logic [2:0] CMD_RESEED = 3'd0;
  localparam logic [2:0] CMD_RAW    = 3'd1;
  localparam logic [2:0] CMD_RANGE  = 3'd2;
  localparam logic [2:0] CMD_BELOW  = 3'd3;
  localparam logic [2:0] CMD_GAUSS  = 3'd4;
  localparam logic [2:0] CMD_TABLE  = 3'd5;
  localparam logic [2:0] CMD_TERN   = 3'd6;
  localparam logic [2:0] CMD_NONE   = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       adv;
    logic       mul;
    logic       red1;
    logic       red2;
    logic       out_load;
    logic       pass;
    logic [2:0] op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Magnitude of table entries 0..100 in Q16.16
  function automatic logic [17:0] half_tab(input logic [6:0] k);
    logic [17:0] v;
    unique case (k)
      7'd0: v = 18'd238733;  7'd1: v = 18'd119366;  7'd2: v = 18'd107805;
      7'd3: v = 18'd100564;  7'd4: v = 18'd95173;   7'd5: v = 18'd90827;
      7'd6: v = 18'd87158;   7'd7: v = 18'd83966;   7'd8: v = 18'd81128;
      7'd9: v = 18'd78566;   7'd10: v = 18'd76224;  7'd11: v = 18'd74062;
      7'd12: v = 18'd72050;  7'd13: v = 18'd70165;  7'd14: v = 18'd68390;
      7'd15: v = 18'd66709;  7'd16: v = 18'd65112;  7'd17: v = 18'd63589;
      7'd18: v = 18'd62132;  7'd19: v = 18'd60733;  7'd20: v = 18'd59388;
      7'd21: v = 18'd58091;  7'd22: v = 18'd56838;  7'd23: v = 18'd55626;
      7'd24: v = 18'd54450;  7'd25: v = 18'd53308;  7'd26: v = 18'd52198;
      7'd27: v = 18'd51117;  7'd28: v = 18'd50063;  7'd29: v = 18'd49034;
      7'd30: v = 18'd48029;  7'd31: v = 18'd47046;  7'd32: v = 18'd46084;
      7'd33: v = 18'd45141;  7'd34: v = 18'd44217;  7'd35: v = 18'd43310;
      7'd36: v = 18'd42419;  7'd37: v = 18'd41543;  7'd38: v = 18'd40683;
      7'd39: v = 18'd39835;  7'd40: v = 18'd39002;  7'd41: v = 18'd38180;
      7'd42: v = 18'd37370;  7'd43: v = 18'd36572;  7'd44: v = 18'd35784;
      7'd45: v = 18'd35007;  7'd46: v = 18'd34239;  7'd47: v = 18'd33480;
      7'd48: v = 18'd32731;  7'd49: v = 18'd31990;  7'd50: v = 18'd31256;
      7'd51: v = 18'd30531;  7'd52: v = 18'd29813;  7'd53: v = 18'd29102;
      7'd54: v = 18'd28398;  7'd55: v = 18'd27701;  7'd56: v = 18'd27009;
      7'd57: v = 18'd26324;  7'd58: v = 18'd25644;  7'd59: v = 18'd24970;
      7'd60: v = 18'd24301;  7'd61: v = 18'd23637;  7'd62: v = 18'd22978;
      7'd63: v = 18'd22324;  7'd64: v = 18'd21674;  7'd65: v = 18'd21028;
      7'd66: v = 18'd20386;  7'd67: v = 18'd19748;  7'd68: v = 18'd19114;
      7'd69: v = 18'd18483;  7'd70: v = 18'd17856;  7'd71: v = 18'd17232;
      7'd72: v = 18'd16611;  7'd73: v = 18'd15993;  7'd74: v = 18'd15378;
      7'd75: v = 18'd14766;  7'd76: v = 18'd14156;  7'd77: v = 18'd13549;
      7'd78: v = 18'd12944;  7'd79: v = 18'd12341;  7'd80: v = 18'd11740;
      7'd81: v = 18'd11142;  7'd82: v = 18'd10545;  7'd83: v = 18'd9949;
      7'd84: v = 18'd9356;   7'd85: v = 18'd8764;   7'd86: v = 18'd8173;
      7'd87: v = 18'd7584;   7'd88: v = 18'd6996;   7'd89: v = 18'd6409;
      7'd90: v = 18'd5823;   7'd91: v = 18'd5238;   7'd92: v = 18'd4654;
      7'd93: v = 18'd4071;   7'd94: v = 18'd3488;   7'd95: v = 18'd2906;
      7'd96: v = 18'd2324;   7'd97: v = 18'd1743;   7'd98: v = 18'd1162;
      7'd99: v = 18'd581;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // Signed table entry 0..200, odd about entry 100
  function automatic logic signed [18:0] tab_at(input logic [7:0] k);
    logic [7:0] m;
    logic signed [18:0] r;
    m = 8'd200 - k;
    if (k <= 8'd100) r = -$signed({1'b0, half_tab(k[6:0])});
    else             r = $signed({1'b0, half_tab(m[6:0])});
    return r;
  endfunction

endpackage

// ===== rtl/msrs_ctrl.sv =====
// Controller state machine for the minimal standard random source.
`timescale 1ns / 1ps
module msrs_ctrl
  import msrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_cmd_i,
  output logic       in_ready_o,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RED1 = 3'd3;
  localparam logic [2:0] ST_RED2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [3:0] cnt_q, cnt_d;
  logic       pass_q, pass_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = in_cmd_i;
          cnt_d   = 4'd0;
          pass_d  = 1'b0;
          state_d = (in_cmd_i == CMD_NONE) ? ST_OUT : ST_ADV;
        end
      end
      ST_ADV: begin
        if (op_q == CMD_GAUSS && cnt_q != GAUSS_LAST) begin
          cnt_d = cnt_q + 4'd1;
        end else if (op_q == CMD_RESEED || op_q == CMD_RAW || op_q == CMD_TERN) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_RED1;
      ST_RED1: state_d = ST_RED2;
      ST_RED2: begin
        if (!pass_q && (op_q == CMD_GAUSS || op_q == CMD_TABLE)) begin
          pass_d  = 1'b1;
          state_d = ST_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.adv      = (state_q == ST_ADV);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.red1     = (state_q == ST_RED1);
    cmd_o.red2     = (state_q == ST_RED2);
    cmd_o.out_load = (state_q == ST_OUT) && stat_i.out_free;
    cmd_o.pass     = pass_q;
    cmd_o.op       = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= CMD_NONE;
      cnt_q   <= 4'd0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== rtl/msrs_dp.sv =====
// Datapath for the minimal standard random source: state, multiplier, mod-M reduction, output.
`timescale 1ns / 1ps
module msrs_dp
  import msrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dp_cmd_t      cmd_i,
  output dp_stat_t     stat_o,
  input  logic [222:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  out_data_o
);

  // Input fields
  logic [2:0]         f_cmd;
  logic [30:0]        f_seed;
  logic signed [31:0] f_min, f_max, f_mean;
  logic [30:0]        f_dev, f_p1, f_p2;

  assign f_cmd  = in_data_i[2:0];
  assign f_seed = in_data_i[33:3];
  assign f_min  = in_data_i[65:34];
  assign f_max  = in_data_i[97:66];
  assign f_mean = in_data_i[129:98];
  assign f_dev  = in_data_i[160:130];
  assign f_p1   = in_data_i[191:161];
  assign f_p2   = in_data_i[222:192];

  logic signed [31:0] min_q, max_q, mean_q;
  logic [30:0]        dev_q, p1_q, p2_q;
  logic [30:0]        s_q, s_d;
  logic [34:0]        sum_q;
  logic signed [64:0] prod_q;
  logic signed [33:0] q0_q;
  logic signed [34:0] r1_q;
  logic signed [34:0] quo_q;
  logic [30:0]        rem_q;
  logic signed [8:0]  sv_q;
  logic signed [35:0] qd_q;
  logic               out_valid_q;
  logic [63:0]        out_data_q;

  function automatic logic signed [32:0] f_ext(input logic signed [31:0] v);
    return 33'(v);
  endfunction

  // Advance: S*16807 folded mod 2^31-1
  logic [45:0] adv_p;
  logic [31:0] adv_t;
  logic [30:0] s_next;
  assign adv_p  = s_q * MULT;
  assign adv_t  = {1'b0, adv_p[30:0]} + {17'd0, adv_p[45:31]};
  assign s_next = (adv_t >= {1'b0, MODM}) ? 31'(adv_t - {1'b0, MODM}) : adv_t[30:0];

  // Reseed value
  logic [30:0] seed_v;
  assign seed_v = (f_seed == MODM || f_seed == 31'd0) ? 31'd1 : f_seed;

  always_comb begin
    s_d = s_q;
    if (cmd_i.load && f_cmd == CMD_RESEED) s_d = seed_v;
    else if (cmd_i.adv)                    s_d = s_next;
  end

  // Table entries around the saved index
  logic [7:0]         tab_i;
  logic signed [18:0] t0, t1, tdiff;
  assign tab_i = sv_q[7:0];
  assign t0    = tab_at(tab_i);
  assign t1    = tab_at(tab_i + 8'd1);
  assign tdiff = t1 - t0;

  // Select multiplier operands
  logic signed [32:0] op_a, op_b;
  logic signed [35:0] gsum;
  assign gsum = $signed({1'b0, sum_q}) - $signed({2'b00, 34'(6 * 64'(MODM))});

  always_comb begin
    op_a = $signed({2'b00, s_q});
    op_b = 33'sd0;
    priority case (1'b1)
      cmd_i.op == CMD_RANGE: op_b = 33'(f_ext(max_q) - f_ext(min_q));
      cmd_i.op == CMD_BELOW: op_b = f_ext(max_q);
      cmd_i.op == CMD_TABLE && !cmd_i.pass: op_b = $signed({24'd0, TAB_STEPS});
      cmd_i.op == CMD_TABLE: begin
        op_a = $signed({2'b00, rem_q});
        op_b = 33'(tdiff);
      end
      cmd_i.op == CMD_GAUSS: begin
        op_a = $signed({2'b00, rem_q});
        op_b = $signed({2'b00, dev_q});
      end
      default: op_b = 33'sd0;
    endcase
  end

  // Floor division by M: fold twice, then one correction
  logic signed [33:0] q0_d;
  logic signed [34:0] r1_d;
  logic signed [3:0]  q1;
  logic signed [32:0] r2;
  logic signed [34:0] quo_d;
  logic [30:0]        rem_d;
  assign q0_d = 34'(prod_q >>> 31);
  assign r1_d = 35'(q0_d) + $signed({4'd0, prod_q[30:0]});
  assign q1   = 4'(r1_q >>> 31);
  assign r2   = 33'(q1) + $signed({2'b00, r1_q[30:0]});

  always_comb begin
    quo_d = 35'(q0_q) + 35'(q1);
    rem_d = r2[30:0];
    if (r2 < 0) begin
      quo_d = quo_d - 35'sd1;
      rem_d = 31'(r2 + $signed({2'b00, MODM}));
    end else if (r2 >= $signed({2'b00, MODM})) begin
      quo_d = quo_d + 35'sd1;
      rem_d = 31'(r2 - $signed({2'b00, MODM}));
    end
  end

  // Result formation
  logic signed [37:0] gtot;
  logic signed [31:0] res_v;
  logic               sat_v;
  assign gtot = 38'(mean_q) + 38'(qd_q) + 38'(quo_q);

  always_comb begin
    res_v = 32'sd0;
    sat_v = 1'b0;
    unique case (cmd_i.op)
      CMD_RESEED, CMD_RAW: res_v = $signed({1'b0, s_q});
      CMD_RANGE: res_v = min_q + quo_q[31:0];
      CMD_BELOW: res_v = (max_q > 0) ? quo_q[31:0] : 32'sd0;
      CMD_GAUSS: begin
        if (gtot > 38'sh0_7FFF_FFFF) begin
          res_v = 32'sh7FFF_FFFF;
          sat_v = 1'b1;
        end else if (gtot < -38'sh0_8000_0000) begin
          res_v = 32'sh8000_0000;
          sat_v = 1'b1;
        end else begin
          res_v = gtot[31:0];
        end
      end
      CMD_TABLE: res_v = 32'(t0) + quo_q[31:0];
      CMD_TERN: begin
        if (s_q > p2_q)      res_v = 32'sd0;
        else if (s_q < p1_q) res_v = -32'sd1;
        else                 res_v = 32'sd1;
      end
      default: res_v = 32'sd0;
    endcase
  end

  // Hold payload and work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_q  <= f_min;
      max_q  <= f_max;
      mean_q <= f_mean;
      dev_q  <= f_dev;
      p1_q   <= f_p1;
      p2_q   <= f_p2;
      sum_q  <= 35'd0;
    end
    if (cmd_i.adv) sum_q <= sum_q + {4'd0, s_next};
    if (cmd_i.mul) begin
      if (cmd_i.op == CMD_GAUSS && !cmd_i.pass) prod_q <= 65'(gsum);
      else                                      prod_q <= op_a * op_b;
      if (cmd_i.op == CMD_GAUSS && cmd_i.pass) qd_q <= 36'(sv_q) * $signed({5'd0, dev_q});
    end
    if (cmd_i.red1) begin
      q0_q <= q0_d;
      r1_q <= r1_d;
    end
    if (cmd_i.red2) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (!cmd_i.pass) sv_q <= quo_d[8:0];
    end
    if (cmd_i.out_load) out_data_q <= {sat_v, s_q, res_v};
  end

  // Generator state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q         <= RESET_STATE;
      out_valid_q <= 1'b0;
    end else begin
      s_q <= s_d;
      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

// ===== rtl/minimal_standard_random_source.sv =====
// Top level of the minimal standard random source (multiplier 16807, modulus 2^31-1).
// Raw, reseed and ternary advance the generator once; range and below-max add one multiply/reduce pass;
// table and gaussian add two (gaussian after twelve generator advances, one per cycle).
// One transaction at a time: the next is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) loads state 198195254 and empties the output register.
`timescale 1ns / 1ps
module minimal_standard_random_source
  import msrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], seed_in[33:3], range_min[65:34], range_max[97:66], mean[129:98],
  // deviation[160:130], prob_first[191:161], prob_second[222:192], zero[223]
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0], state_value[62:32], saturated[63]
  output logic [63:0]  m_axis_tdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  msrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tdata[2:0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  msrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (s_axis_tdata[222:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
